>>> sv/tsri_pkg.sv
// Shared types and constants for the timestamp range index unit.
package tsri_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned CHUNK_W = 32;
  localparam int unsigned ENTRY_W = TIME_W + CHUNK_W;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic {
    PH_LOWER = 1'b0,
    PH_UPPER = 1'b1
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_PHASE_END,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic               found;
    logic [CHUNK_W-1:0] first_chunk;
    logic [CHUNK_W-1:0] last_chunk;
    logic               dropped;
  } result_t;

endpackage

>>> sv/tsri_if.sv
// Request and response channel interfaces of the timestamp range index unit.
interface tsri_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] event_time_ns;
  logic [31:0] event_chunk;
  logic [63:0] range_start_ns;
  logic [63:0] range_end_ns;

  modport source (
    output valid, op, event_time_ns, event_chunk, range_start_ns, range_end_ns,
    input  ready
  );
  modport sink (
    input  valid, op, event_time_ns, event_chunk, range_start_ns, range_end_ns,
    output ready
  );
endinterface

interface tsri_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] first_chunk;
  logic [31:0] last_chunk;
  logic        dropped;

  modport source (
    output valid, found, first_chunk, last_chunk, dropped,
    input  ready
  );
  modport sink (
    input  valid, found, first_chunk, last_chunk, dropped,
    output ready
  );
endinterface

>>> sv/tsri_ram.sv
// Generic single-port synchronous RAM with registered read data.
module tsri_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tsri_ctrl.sv
// Sequencer: appends, two binary searches over the table RAM, chunk id fetch.
module tsri_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  tsri_req_if.sink                req_i,
  output logic                    ram_we_o,
  output logic [AW-1:0]           ram_addr_o,
  output logic [tsri_pkg::ENTRY_W-1:0] ram_wdata_o,
  input  logic [tsri_pkg::ENTRY_W-1:0] ram_rdata_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output tsri_pkg::result_t       res_o
);
  import tsri_pkg::*;

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, lpos_q, lpos_d;
  logic [TIME_W-1:0] start_q, start_d, end_q, end_d;
  result_t       res_q, res_d;

  logic              accept;
  logic              is_query;
  logic              full;
  logic [TIME_W-1:0] rd_time;
  logic              go_right;
  logic [CW-1:0]     mid_p1;
  logic [CW-1:0]     nmid_r, nmid_l;
  logic              cont_r, cont_l;
  logic              found_now;

  assign accept    = req_i.valid && (state_q == ST_IDLE);
  assign is_query  = (req_i.op == OP_QUERY);
  assign full      = (count_q >= CW'(TABLE_DEPTH));
  assign rd_time   = ram_rdata_i[ENTRY_W-1 -: TIME_W];
  assign found_now = (lpos_q < lo_q);

  // go_right: the probed entry lies before the searched position
  assign go_right = (phase_q == PH_LOWER) ? (rd_time < start_q) : !(end_q < rd_time);
  assign mid_p1   = mid_q + CW'(1);
  assign nmid_r   = mid_p1 + ((hi_q - mid_p1) >> 1);
  assign cont_r   = (mid_p1 < hi_q);
  assign nmid_l   = lo_q + ((mid_q - lo_q) >> 1);
  assign cont_l   = (lo_q < mid_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!is_query) begin
            state_d = ST_RESP;
          end else if (count_q != '0) begin
            state_d = ST_SEEK;
          end else begin
            state_d = ST_PHASE_END;
          end
        end
      end
      ST_SEEK: begin
        if ((go_right && !cont_r) || (!go_right && !cont_l)) begin
          state_d = ST_PHASE_END;
        end
      end
      ST_PHASE_END: begin
        if (phase_q == PH_LOWER) begin
          state_d = (count_q != '0) ? ST_SEEK : ST_PHASE_END;
        end else begin
          state_d = found_now ? ST_RD_FIRST : ST_RESP;
        end
      end
      ST_RD_FIRST: state_d = ST_RD_LAST;
      ST_RD_LAST:  state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    lpos_d  = lpos_q;
    start_d = start_q;
    end_d   = end_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_query) begin
            start_d = req_i.range_start_ns;
            end_d   = req_i.range_end_ns;
            phase_d = PH_LOWER;
            lo_d    = '0;
            hi_d    = count_q;
            mid_d   = count_q >> 1;
          end else begin
            res_d = '{found: 1'b0, first_chunk: '0, last_chunk: '0, dropped: full};
            if (!full) begin
              count_d = count_q + CW'(1);
            end
          end
        end
      end
      ST_SEEK: begin
        if (go_right) begin
          lo_d  = mid_p1;
          mid_d = nmid_r;
        end else begin
          hi_d  = mid_q;
          mid_d = nmid_l;
        end
      end
      ST_PHASE_END: begin
        if (phase_q == PH_LOWER) begin
          lpos_d  = lo_q;
          phase_d = PH_UPPER;
          lo_d    = '0;
          hi_d    = count_q;
          mid_d   = count_q >> 1;
        end else begin
          res_d = '{found: found_now, first_chunk: '0, last_chunk: '0, dropped: 1'b0};
        end
      end
      ST_RD_FIRST: res_d.first_chunk = ram_rdata_i[CHUNK_W-1:0];
      ST_RD_LAST:  res_d.last_chunk  = ram_rdata_i[CHUNK_W-1:0];
      ST_RESP: ;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    ram_we_o    = 1'b0;
    ram_addr_o  = mid_d[AW-1:0];
    ram_wdata_o = {req_i.event_time_ns, req_i.event_chunk};
    res_valid_o = (state_q == ST_RESP);
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !is_query) begin
          ram_we_o   = !full;
          ram_addr_o = count_q[AW-1:0];
        end
      end
      ST_PHASE_END: begin
        if (phase_q == PH_UPPER) begin
          ram_addr_o = lpos_q[AW-1:0];
        end
      end
      ST_RD_FIRST: begin
        ram_addr_o = lo_q[AW-1:0] - AW'(1);
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_LOWER;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    lpos_q  <= lpos_d;
    start_q <= start_d;
    end_q   <= end_d;
    res_q   <= res_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_seek_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEEK |-> lo_q <= mid_q && mid_q < hi_q && hi_q <= count_q)
    else $error("search probe outside its window");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(accept && !is_query) && count_q == $past(count_q) + CW'(1))
    else $error("entry count moved without an append");

  a_found_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD_LAST |-> res_q.found && $past(state_q == ST_RD_FIRST))
    else $error("chunk fetch without a hit");

endmodule

>>> sv/timestamp_range_index_unit.sv
// Top level: table RAM, search sequencer and response output register.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   op, event_time_ns, event_chunk, range_start_ns, range_end_ns
//   rsp_o    out  valid/ready   found, first_chunk, last_chunk, dropped
//
// One request at a time. A query's length is set by the one-read-per-step binary
// searches on the single RAM port; with a hit it also reads the first and last
// chunk ids.
// Reset clears the entry count and sequencer; table contents are not cleared.
// A stalled response holds in the output register; the next request is
// accepted meanwhile and waits only if its own result finds the register full.
module timestamp_range_index_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsri_req_if.sink  req_i,
  tsri_rsp_if.source rsp_o
);
  import tsri_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  tsri_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  tsri_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = out_q.found;
  assign rsp_o.first_chunk = out_q.first_chunk;
  assign rsp_o.last_chunk  = out_q.last_chunk;
  assign rsp_o.dropped     = out_q.dropped;

endmodule
